// ----- src/mteu_pkg.sv -----
// Constants, types and entity tables for the markup text extract and unescape block.
`default_nettype none

package mteu_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [20:0] t_code;

    localparam int unsigned NUM_NAMES = 5;

    localparam t_byte CH_LT    = 8'h3C;
    localparam t_byte CH_GT    = 8'h3E;
    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_SEMI  = 8'h3B;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_X     = 8'h78;
    localparam t_byte CH_QUOT  = 8'h22;
    localparam t_byte CH_APOS  = 8'h27;

    localparam t_code CODE_LO1_MAX = 21'h00D7FF;
    localparam t_code CODE_LO2_MIN = 21'h00E000;
    localparam t_code CODE_LO2_MAX = 21'h00FFFD;
    localparam t_code CODE_HI_MIN  = 21'h010000;
    localparam t_code CODE_MAX     = 21'h10FFFF;

    // length of entity name, terminating semicolon included
    function automatic logic [2:0] name_len(input logic [2:0] idx);
        unique case (idx)
            3'd0, 3'd1: name_len = 3'd3;
            3'd2:       name_len = 3'd4;
            default:    name_len = 3'd5;
        endcase
    endfunction

    function automatic t_byte name_byte(input logic [2:0] idx, input logic [2:0] pos);
        name_byte = 8'h00;
        unique case (idx)
            3'd0: begin
                unique case (pos)
                    3'd0:    name_byte = "l";
                    3'd1:    name_byte = "t";
                    3'd2:    name_byte = CH_SEMI;
                    default: name_byte = 8'h00;
                endcase
            end
            3'd1: begin
                unique case (pos)
                    3'd0:    name_byte = "g";
                    3'd1:    name_byte = "t";
                    3'd2:    name_byte = CH_SEMI;
                    default: name_byte = 8'h00;
                endcase
            end
            3'd2: begin
                unique case (pos)
                    3'd0:    name_byte = "a";
                    3'd1:    name_byte = "m";
                    3'd2:    name_byte = "p";
                    3'd3:    name_byte = CH_SEMI;
                    default: name_byte = 8'h00;
                endcase
            end
            3'd3: begin
                unique case (pos)
                    3'd0:    name_byte = "q";
                    3'd1:    name_byte = "u";
                    3'd2:    name_byte = "o";
                    3'd3:    name_byte = "t";
                    3'd4:    name_byte = CH_SEMI;
                    default: name_byte = 8'h00;
                endcase
            end
            3'd4: begin
                unique case (pos)
                    3'd0:    name_byte = "a";
                    3'd1:    name_byte = "p";
                    3'd2:    name_byte = "o";
                    3'd3:    name_byte = "s";
                    3'd4:    name_byte = CH_SEMI;
                    default: name_byte = 8'h00;
                endcase
            end
            default: name_byte = 8'h00;
        endcase
    endfunction

    function automatic t_byte name_char(input logic [2:0] idx);
        unique case (idx)
            3'd0:    name_char = CH_LT;
            3'd1:    name_char = CH_GT;
            3'd2:    name_char = CH_AMP;
            3'd3:    name_char = CH_QUOT;
            default: name_char = CH_APOS;
        endcase
    endfunction

    function automatic logic code_allowed(input t_code c);
        code_allowed = (c >= 21'd1 && c <= CODE_LO1_MAX) ||
                       (c >= CODE_LO2_MIN && c <= CODE_LO2_MAX) ||
                       (c >= CODE_HI_MIN && c <= CODE_MAX);
    endfunction

endpackage

`default_nettype wire

// ----- src/mteu_in_if.sv -----
// Request channel carrying markup text bytes.
`default_nettype none

interface mteu_in_if;
    logic            valid;
    logic            ready;
    mteu_pkg::t_byte in_byte;
    logic            in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ----- src/mteu_out_if.sv -----
// Result channel carrying plain text bytes and end of text status.
`default_nettype none

interface mteu_out_if;
    logic            valid;
    logic            ready;
    mteu_pkg::t_byte out_byte;
    logic            byte_valid;
    logic            end_of_text;
    logic            decode_error;

    modport source (output valid, output out_byte, output byte_valid, output end_of_text,
                    output decode_error, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input end_of_text,
                    input decode_error, output ready);
endinterface

`default_nettype wire

// ----- src/markup_text_extract_unescape_top.sv -----
// Markup text extractor: strips tags, folds CR/CRLF to LF and decodes entities to UTF-8.
//
// One markup byte is taken per request. Tags are removed, the remaining text is unescaped
// and each request yields zero to four plain-text bytes, presented one per cycle while
// the result channel is ready, starting the cycle after the request is taken. A request
// that yields at most one byte is taken every cycle while the result channel is ready;
// one that decodes to n UTF-8 bytes occupies the result register, and so the request
// channel, until its last byte is taken. The final byte of a text always yields at
// least one result, and its last result carries end_of_text and decode_error. After a
// malformed entity the rest of the text yields nothing until the final byte.
`default_nettype none

module markup_text_extract_unescape_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mteu_in_if.sink           i_in,
    mteu_out_if.source        o_out
);

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_AMP   = 3'd1,
        MODE_NAME  = 3'd2,
        MODE_HASH  = 3'd3,
        MODE_DEC   = 3'd4,
        MODE_HEX   = 3'd5
    } t_mode;

    // parse state
    logic              r_in_tag,  n_in_tag;
    t_mode             r_mode,    n_mode;
    logic [4:0]        r_cand,    n_cand;
    logic [2:0]        r_npos,    n_npos;
    mteu_pkg::t_code   r_acc,     n_acc;
    logic              r_ovf,     n_ovf;
    logic              r_dig,     n_dig;
    logic              r_cr,      n_cr;
    logic              r_err,     n_err;

    // result register
    mteu_pkg::t_byte   r_ob [4];
    logic [2:0]        r_rem;
    logic [1:0]        r_pos;
    logic              r_bv;
    logic              r_end;
    logic              r_derr;

    mteu_pkg::t_byte   e_b [4];
    logic [2:0]        e_cnt;
    logic              e_bv;
    logic              e_derr;

    mteu_pkg::t_byte   b;
    logic              in_fire;
    logic              out_fire;
    logic              do_name;
    logic              do_dig;
    logic              hex;
    logic [4:0]        hit;
    logic [4:0]        done;
    logic [2:0]        done_idx;
    logic              is_dec;
    logic              is_hl;
    logic              is_hu;
    logic              d_ok;
    logic [3:0]        d;
    logic [24:0]       v;

    assign b        = i_in.in_byte;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    assign i_in.ready = (r_rem == 3'd0) || ((r_rem == 3'd1) && o_out.ready);

    assign o_out.valid        = (r_rem != 3'd0);
    assign o_out.out_byte     = r_ob[r_pos];
    assign o_out.byte_valid   = r_bv;
    assign o_out.end_of_text  = r_end && (r_rem == 3'd1);
    assign o_out.decode_error = r_derr && (r_rem == 3'd1);

    // entity name match
    always_comb begin
        done_idx = 3'd0;
        for (int i = 0; i < mteu_pkg::NUM_NAMES; i++) begin
            hit[i]  = r_cand[i] && (r_npos < mteu_pkg::name_len(3'(i))) &&
                      (mteu_pkg::name_byte(3'(i), r_npos) == b);
            done[i] = hit[i] && ((r_npos + 3'd1) == mteu_pkg::name_len(3'(i)));
        end
        for (int i = mteu_pkg::NUM_NAMES - 1; i >= 0; i--) begin
            if (done[i]) begin
                done_idx = 3'(i);
            end
        end
    end

    // digit decode and accumulate
    always_comb begin
        hex    = (r_mode == MODE_HEX);
        is_dec = (b >= "0") && (b <= "9");
        is_hl  = hex && (b >= "a") && (b <= "f");
        is_hu  = hex && (b >= "A") && (b <= "F");
        d_ok   = is_dec || is_hl || is_hu;
        if (is_dec) begin
            d = 4'(b - "0");
        end else if (is_hl) begin
            d = 4'(b - "a" + 8'd10);
        end else begin
            d = 4'(b - "A" + 8'd10);
        end
        if (hex) begin
            v = 25'({r_acc, 4'b0000}) + 25'(d);
        end else begin
            v = 25'({r_acc, 3'b000}) + 25'({r_acc, 1'b0}) + 25'(d);
        end
    end

    always_comb begin
        n_in_tag = r_in_tag;
        n_mode   = r_mode;
        n_cand   = r_cand;
        n_npos   = r_npos;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_dig    = r_dig;
        n_cr     = r_cr;
        n_err    = r_err;
        e_cnt    = 3'd0;
        e_bv     = 1'b1;
        e_derr   = 1'b0;
        do_name  = 1'b0;
        do_dig   = 1'b0;
        for (int k = 0; k < 4; k++) begin
            e_b[k] = 8'h00;
        end

        if (!r_err) begin
            if (r_in_tag) begin
                if (b == mteu_pkg::CH_GT) begin
                    n_in_tag = 1'b0;
                end
            end else if (b == mteu_pkg::CH_LT) begin
                n_in_tag = 1'b1;
            end else begin
                unique case (r_mode)
                    MODE_PLAIN: begin
                        n_cr = 1'b0;
                        if (r_cr && (b == mteu_pkg::CH_LF)) begin
                            // drop LF of CRLF
                        end else if (b == mteu_pkg::CH_CR) begin
                            e_cnt  = 3'd1;
                            e_b[0] = mteu_pkg::CH_LF;
                            n_cr   = 1'b1;
                        end else if (b == mteu_pkg::CH_AMP) begin
                            n_mode = MODE_AMP;
                            n_cand = '1;
                            n_npos = 3'd0;
                            n_acc  = '0;
                            n_ovf  = 1'b0;
                            n_dig  = 1'b0;
                        end else begin
                            e_cnt  = 3'd1;
                            e_b[0] = b;
                        end
                    end
                    MODE_AMP: begin
                        if (b == mteu_pkg::CH_HASH) begin
                            n_mode = MODE_HASH;
                        end else begin
                            do_name = 1'b1;
                        end
                    end
                    MODE_NAME: begin
                        do_name = 1'b1;
                    end
                    MODE_HASH: begin
                        if (b == mteu_pkg::CH_X) begin
                            n_mode = MODE_HEX;
                        end else begin
                            n_mode = MODE_DEC;
                            do_dig = 1'b1;
                        end
                    end
                    MODE_DEC, MODE_HEX: begin
                        do_dig = 1'b1;
                    end
                    default: begin
                        n_mode = MODE_PLAIN;
                        n_err  = 1'b1;
                    end
                endcase
            end
        end

        if (do_name) begin
            if (done != 5'd0) begin
                n_mode = MODE_PLAIN;
                e_cnt  = 3'd1;
                e_b[0] = mteu_pkg::name_char(done_idx);
            end else if (hit == 5'd0) begin
                n_mode = MODE_PLAIN;
                n_err  = 1'b1;
            end else begin
                n_cand = hit;
                n_npos = r_npos + 3'd1;
                n_mode = MODE_NAME;
            end
        end

        if (do_dig) begin
            if (d_ok) begin
                n_dig = 1'b1;
                if (!r_ovf) begin
                    if (v > 25'(mteu_pkg::CODE_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = v[20:0];
                    end
                end
            end else if ((b == mteu_pkg::CH_SEMI) && r_dig && !r_ovf &&
                         mteu_pkg::code_allowed(r_acc)) begin
                n_mode = MODE_PLAIN;
                if (r_acc < 21'h80) begin
                    e_cnt  = 3'd1;
                    e_b[0] = r_acc[7:0];
                end else if (r_acc < 21'h800) begin
                    e_cnt  = 3'd2;
                    e_b[0] = {3'b110, r_acc[10:6]};
                    e_b[1] = {2'b10, r_acc[5:0]};
                end else if (r_acc < mteu_pkg::CODE_HI_MIN) begin
                    e_cnt  = 3'd3;
                    e_b[0] = {4'b1110, r_acc[15:12]};
                    e_b[1] = {2'b10, r_acc[11:6]};
                    e_b[2] = {2'b10, r_acc[5:0]};
                end else begin
                    e_cnt  = 3'd4;
                    e_b[0] = {5'b11110, r_acc[20:18]};
                    e_b[1] = {2'b10, r_acc[17:12]};
                    e_b[2] = {2'b10, r_acc[11:6]};
                    e_b[3] = {2'b10, r_acc[5:0]};
                end
            end else begin
                n_mode = MODE_PLAIN;
                n_err  = 1'b1;
            end
        end

        // clear entity fields whenever the parser returns to plain text
        if (n_mode == MODE_PLAIN && r_mode != MODE_PLAIN) begin
            n_cand = '1;
            n_npos = 3'd0;
            n_acc  = '0;
            n_ovf  = 1'b0;
            n_dig  = 1'b0;
        end

        if (i_in.in_last) begin
            e_derr = n_err || (n_mode != MODE_PLAIN);
            if (e_cnt == 3'd0) begin
                e_cnt  = 3'd1;
                e_bv   = 1'b0;
                e_b[0] = 8'h00;
            end
            n_in_tag = 1'b0;
            n_mode   = MODE_PLAIN;
            n_cand   = '1;
            n_npos   = 3'd0;
            n_acc    = '0;
            n_ovf    = 1'b0;
            n_dig    = 1'b0;
            n_cr     = 1'b0;
            n_err    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag <= 1'b0;
            r_mode   <= MODE_PLAIN;
            r_cand   <= '1;
            r_npos   <= 3'd0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_dig    <= 1'b0;
            r_cr     <= 1'b0;
            r_err    <= 1'b0;
            r_rem    <= 3'd0;
            r_pos    <= 2'd0;
            r_bv     <= 1'b0;
            r_end    <= 1'b0;
            r_derr   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_tag <= n_in_tag;
                r_mode   <= n_mode;
                r_cand   <= n_cand;
                r_npos   <= n_npos;
                r_acc    <= n_acc;
                r_ovf    <= n_ovf;
                r_dig    <= n_dig;
                r_cr     <= n_cr;
                r_err    <= n_err;
                r_rem    <= e_cnt;
                r_pos    <= 2'd0;
                r_bv     <= e_bv;
                r_end    <= i_in.in_last;
                r_derr   <= e_derr;
            end else if (out_fire) begin
                r_rem <= r_rem - 3'd1;
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < 4; k++) begin
                r_ob[k] <= e_b[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_markup_text_extract_unescape_top.sv -----
// Self-checking testbench for the markup text extract and unescape block.
`timescale 1ns / 1ps

module tb_markup_text_extract_unescape_top;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_ITEMS  = 240;
    localparam int IDLE_PCT      = 34;
    localparam int REQ_CALM_FROM = 60;
    localparam int REQ_CALM_TO   = 130;
    localparam int PAUSE_AT      = 200;
    localparam int HOLD_FROM     = 150;
    localparam int HOLD_LEN      = 200;
    localparam int RES_CALM_FROM = 450;
    localparam int RES_CALM_TO   = 600;
    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 2000;

    typedef enum logic [2:0] {
        PM_PLAIN, PM_AMP, PM_NAME, PM_HASH, PM_DEC, PM_HEX
    } t_entity_mode;

    typedef enum logic [2:0] {
        FLAW_BYTE, FLAW_CODE, FLAW_EMPTY, FLAW_UPPER_X, FLAW_NAME, FLAW_OPEN
    } t_flaw;

    typedef struct packed {
        mteu_pkg::t_byte out_byte;
        logic            byte_valid;
        logic            end_of_text;
        logic            decode_error;
    } t_text_result;

    typedef struct packed {
        mteu_pkg::t_byte in_byte;
        logic            is_final;
        logic            fixed;
        t_text_result    typed;
    } t_text_req;

    localparam t_text_result NO_TYPED = '0;

    localparam int ENT_LEN [mteu_pkg::NUM_NAMES] = '{3, 3, 4, 5, 5};
    localparam mteu_pkg::t_byte ENT_GLYPH [mteu_pkg::NUM_NAMES] = '{
        mteu_pkg::CH_LT, mteu_pkg::CH_GT, mteu_pkg::CH_AMP, mteu_pkg::CH_QUOT,
        mteu_pkg::CH_APOS
    };
    localparam mteu_pkg::t_byte ENT_SPELLING [mteu_pkg::NUM_NAMES][5] = '{
        '{"l", "t", mteu_pkg::CH_SEMI, 8'h00, 8'h00},
        '{"g", "t", mteu_pkg::CH_SEMI, 8'h00, 8'h00},
        '{"a", "m", "p", mteu_pkg::CH_SEMI, 8'h00},
        '{"q", "u", "o", "t", mteu_pkg::CH_SEMI},
        '{"a", "p", "o", "s", mteu_pkg::CH_SEMI}
    };

    localparam t_text_req DIRECTED [DIRECTED_ROWS] = '{
        '{8'h41,            1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},
        '{8'h00,            1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{8'hFF,            1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{mteu_pkg::CH_LT,   1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_AMP,  1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_GT,   1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_CR,   1'b0, 1'b1, '{mteu_pkg::CH_LF, 1'b1, 1'b0, 1'b0}},
        '{mteu_pkg::CH_LF,   1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_AMP,  1'b0, 1'b0, NO_TYPED},
        '{"g",              1'b0, 1'b0, NO_TYPED},
        '{"t",              1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_SEMI, 1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_AMP,  1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_HASH, 1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_X,    1'b0, 1'b0, NO_TYPED},
        '{"1",              1'b0, 1'b0, NO_TYPED},
        '{"F",              1'b0, 1'b0, NO_TYPED},
        '{"6",              1'b0, 1'b0, NO_TYPED},
        '{"0",              1'b0, 1'b0, NO_TYPED},
        '{"0",              1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_SEMI, 1'b0, 1'b0, NO_TYPED},
        '{mteu_pkg::CH_AMP,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{mteu_pkg::CH_AMP,  1'b0, 1'b0, NO_TYPED},
        '{"z",              1'b0, 1'b0, NO_TYPED},
        '{"Q",              1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{"B",              1'b1, 1'b1, '{"B",   1'b1, 1'b1, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    mteu_in_if  req_if ();
    mteu_out_if res_if ();

    markup_text_extract_unescape_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic         pm_in_tag;
    t_entity_mode pm_mode;
    logic [4:0]   pm_cand;
    logic [2:0]   pm_pos;
    int unsigned  pm_code;
    logic         pm_ovf;
    logic         pm_digit;
    logic         pm_after_cr;
    logic         pm_err;

    t_text_result    decoded_bytes[$];
    t_text_result    plain_text_expected[$];
    t_text_req       req_items[$];
    mteu_pkg::t_byte text_draft[$];
    int unsigned     fail_count = 0;

    function automatic void clear_entity();
        pm_mode  = PM_PLAIN;
        pm_cand  = '1;
        pm_pos   = '0;
        pm_code  = 0;
        pm_ovf   = 1'b0;
        pm_digit = 1'b0;
    endfunction

    function automatic void clear_text_state();
        pm_in_tag   = 1'b0;
        pm_after_cr = 1'b0;
        pm_err      = 1'b0;
        clear_entity();
    endfunction

    function automatic void flag_malformed();
        clear_entity();
        pm_err = 1'b1;
    endfunction

    function automatic void push_decoded(mteu_pkg::t_byte b);
        if (decoded_bytes.size() < 4) begin
            decoded_bytes.push_back('{b, 1'b1, 1'b0, 1'b0});
        end
    endfunction

    function automatic void match_entity_name(mteu_pkg::t_byte b);
        logic [4:0] keep;
        keep = '0;
        for (int i = 0; i < mteu_pkg::NUM_NAMES; i++) begin
            if (pm_cand[i] && pm_pos < ENT_LEN[i] && ENT_SPELLING[i][pm_pos] == b) begin
                if (pm_pos + 1 == ENT_LEN[i]) begin
                    clear_entity();
                    push_decoded(ENT_GLYPH[i]);
                    return;
                end
                keep[i] = 1'b1;
            end
        end
        if (keep == '0) begin
            flag_malformed();
        end else begin
            pm_cand = keep;
            pm_pos  = pm_pos + 3'd1;
            pm_mode = PM_NAME;
        end
    endfunction

    function automatic void take_digit(mteu_pkg::t_byte b, logic hex);
        int unsigned d;
        int unsigned v;
        int unsigned c;
        logic        is_digit;
        is_digit = 1'b1;
        d = 0;
        if (b >= "0" && b <= "9") begin
            d = b - "0";
        end else if (hex && b >= "a" && b <= "f") begin
            d = b - "a" + 10;
        end else if (hex && b >= "A" && b <= "F") begin
            d = b - "A" + 10;
        end else begin
            is_digit = 1'b0;
        end
        if (!is_digit) begin
            c = pm_code;
            if (b == mteu_pkg::CH_SEMI && pm_digit && !pm_ovf &&
                ((c >= 1 && c <= mteu_pkg::CODE_LO1_MAX) ||
                 (c >= mteu_pkg::CODE_LO2_MIN && c <= mteu_pkg::CODE_LO2_MAX) ||
                 (c >= mteu_pkg::CODE_HI_MIN && c <= mteu_pkg::CODE_MAX))) begin
                clear_entity();
                if (c < 'h80) begin
                    push_decoded(mteu_pkg::t_byte'(c));
                end else if (c < 'h800) begin
                    push_decoded(mteu_pkg::t_byte'(8'hC0 | (c >> 6)));
                    push_decoded(mteu_pkg::t_byte'(8'h80 | (c & 'h3F)));
                end else if (c < 'h10000) begin
                    push_decoded(mteu_pkg::t_byte'(8'hE0 | (c >> 12)));
                    push_decoded(mteu_pkg::t_byte'(8'h80 | ((c >> 6) & 'h3F)));
                    push_decoded(mteu_pkg::t_byte'(8'h80 | (c & 'h3F)));
                end else begin
                    push_decoded(mteu_pkg::t_byte'(8'hF0 | (c >> 18)));
                    push_decoded(mteu_pkg::t_byte'(8'h80 | ((c >> 12) & 'h3F)));
                    push_decoded(mteu_pkg::t_byte'(8'h80 | ((c >> 6) & 'h3F)));
                    push_decoded(mteu_pkg::t_byte'(8'h80 | (c & 'h3F)));
                end
            end else begin
                flag_malformed();
            end
            return;
        end
        pm_digit = 1'b1;
        if (!pm_ovf) begin
            v = pm_code * (hex ? 16 : 10) + d;
            if (v > mteu_pkg::CODE_MAX) pm_ovf = 1'b1;
            else pm_code = v;
        end
    endfunction

    function automatic void predict_plain_text(mteu_pkg::t_byte b, logic is_final);
        t_text_result tail;
        logic         skip;
        decoded_bytes.delete();
        if (!pm_err) begin
            if (pm_in_tag) begin
                if (b == mteu_pkg::CH_GT) pm_in_tag = 1'b0;
            end else if (b == mteu_pkg::CH_LT) begin
                pm_in_tag = 1'b1;
            end else begin
                case (pm_mode)
                    PM_PLAIN: begin
                        skip = pm_after_cr && b == mteu_pkg::CH_LF;
                        pm_after_cr = 1'b0;
                        if (!skip) begin
                            if (b == mteu_pkg::CH_CR) begin
                                push_decoded(mteu_pkg::CH_LF);
                                pm_after_cr = 1'b1;
                            end else if (b == mteu_pkg::CH_AMP) begin
                                clear_entity();
                                pm_mode = PM_AMP;
                            end else begin
                                push_decoded(b);
                            end
                        end
                    end
                    PM_AMP: begin
                        if (b == mteu_pkg::CH_HASH) pm_mode = PM_HASH;
                        else match_entity_name(b);
                    end
                    PM_NAME: match_entity_name(b);
                    PM_HASH: begin
                        if (b == mteu_pkg::CH_X) begin
                            pm_mode = PM_HEX;
                        end else begin
                            pm_mode = PM_DEC;
                            take_digit(b, 1'b0);
                        end
                    end
                    PM_DEC:  take_digit(b, 1'b0);
                    PM_HEX:  take_digit(b, 1'b1);
                    default: flag_malformed();
                endcase
            end
        end
        if (is_final) begin
            if (decoded_bytes.size() == 0) decoded_bytes.push_back('0);
            tail = decoded_bytes.pop_back();
            tail.end_of_text  = 1'b1;
            tail.decode_error = pm_err || pm_mode != PM_PLAIN;
            decoded_bytes.push_back(tail);
            clear_text_state();
        end
    endfunction

    function automatic void draft_tag();
        int unsigned     n;
        mteu_pkg::t_byte c;
        text_draft.push_back(mteu_pkg::CH_LT);
        n = $urandom_range(4);
        repeat (n) begin
            c = mteu_pkg::t_byte'($urandom_range(255));
            if (c == mteu_pkg::CH_GT) c = "a";
            text_draft.push_back(c);
        end
        text_draft.push_back(mteu_pkg::CH_GT);
    endfunction

    function automatic void draft_name(int unsigned idx, bit split);
        text_draft.push_back(mteu_pkg::CH_AMP);
        for (int i = 0; i < ENT_LEN[idx]; i++) begin
            if (split && $urandom_range(2) == 0) draft_tag();
            text_draft.push_back(ENT_SPELLING[idx][i]);
        end
    endfunction

    function automatic int unsigned pick_code(bit good);
        if (good) begin
            case ($urandom_range(4))
                0: return $urandom_range(8'h7F, 1);
                1: return $urandom_range(12'h7FF, 8'h80);
                2: return $urandom_range(1) ?
                          $urandom_range(mteu_pkg::CODE_LO1_MAX, 12'h800) :
                          $urandom_range(mteu_pkg::CODE_LO2_MAX, mteu_pkg::CODE_LO2_MIN);
                3: return $urandom_range(mteu_pkg::CODE_MAX, mteu_pkg::CODE_HI_MIN);
                default: begin
                    case ($urandom_range(5))
                        0:       return 1;
                        1:       return mteu_pkg::CODE_LO1_MAX;
                        2:       return mteu_pkg::CODE_LO2_MIN;
                        3:       return mteu_pkg::CODE_LO2_MAX;
                        4:       return mteu_pkg::CODE_HI_MIN;
                        default: return mteu_pkg::CODE_MAX;
                    endcase
                end
            endcase
        end
        case ($urandom_range(4))
            0:       return 0;
            1:       return $urandom_range(mteu_pkg::CODE_LO2_MIN - 1,
                                           mteu_pkg::CODE_LO1_MAX + 1);
            2:       return mteu_pkg::CODE_LO2_MAX + 1 + $urandom_range(1);
            3:       return $urandom_range(32'h1FFFFF, mteu_pkg::CODE_MAX + 1);
            default: return $urandom;
        endcase
    endfunction

    function automatic void draft_code(int unsigned c);
        string           s;
        bit              hex;
        mteu_pkg::t_byte ch;
        hex = $urandom_range(1);
        s = hex ? $sformatf("%0h", c) : $sformatf("%0d", c);
        if ($urandom_range(7) == 0) s = {"00", s};
        text_draft.push_back(mteu_pkg::CH_AMP);
        text_draft.push_back(mteu_pkg::CH_HASH);
        if (hex) text_draft.push_back(mteu_pkg::CH_X);
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (hex && ch >= "a" && ch <= "f" && $urandom_range(1)) ch = ch - 8'h20;
            text_draft.push_back(ch);
        end
        text_draft.push_back(mteu_pkg::CH_SEMI);
    endfunction

    function automatic void draft_random_text();
        int unsigned     tokens;
        int unsigned     roll;
        int unsigned     idx;
        bit              open_end;
        mteu_pkg::t_byte c;
        text_draft.delete();
        tokens = $urandom_range(12, 1);
        open_end = 1'b0;
        for (int t = 0; t < tokens && !open_end; t++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                c = mteu_pkg::t_byte'($urandom_range(255));
                if (c == mteu_pkg::CH_LT || c == mteu_pkg::CH_AMP) c = c ^ 8'h01;
                text_draft.push_back(c);
            end else if (roll < 43) begin
                text_draft.push_back(mteu_pkg::CH_CR);
                if ($urandom_range(1)) text_draft.push_back(mteu_pkg::CH_LF);
            end else if (roll < 53) begin
                draft_tag();
            end else if (roll < 68) begin
                draft_name($urandom_range(mteu_pkg::NUM_NAMES - 1), 1'b0);
            end else if (roll < 74) begin
                draft_name($urandom_range(mteu_pkg::NUM_NAMES - 1), 1'b1);
            end else if (roll < 95) begin
                draft_code(pick_code(1'b1));
            end else begin
                case (t_flaw'($urandom_range(5)))
                    FLAW_BYTE: begin
                        text_draft.push_back(mteu_pkg::CH_AMP);
                        text_draft.push_back(mteu_pkg::t_byte'($urandom_range(255)));
                    end
                    FLAW_CODE: draft_code(pick_code(1'b0));
                    FLAW_EMPTY: begin
                        text_draft.push_back(mteu_pkg::CH_AMP);
                        text_draft.push_back(mteu_pkg::CH_HASH);
                        if ($urandom_range(1)) text_draft.push_back(mteu_pkg::CH_X);
                        text_draft.push_back(mteu_pkg::CH_SEMI);
                    end
                    FLAW_UPPER_X: begin
                        text_draft.push_back(mteu_pkg::CH_AMP);
                        text_draft.push_back(mteu_pkg::CH_HASH);
                        text_draft.push_back("X");
                        text_draft.push_back("4");
                        text_draft.push_back("1");
                        text_draft.push_back(mteu_pkg::CH_SEMI);
                    end
                    FLAW_NAME: begin
                        idx = $urandom_range(mteu_pkg::NUM_NAMES - 1);
                        text_draft.push_back(mteu_pkg::CH_AMP);
                        for (int i = 0; i < $urandom_range(ENT_LEN[idx] - 1); i++) begin
                            text_draft.push_back(ENT_SPELLING[idx][i]);
                        end
                        text_draft.push_back("z");
                        text_draft.push_back(mteu_pkg::CH_SEMI);
                    end
                    FLAW_OPEN: begin
                        text_draft.push_back(mteu_pkg::CH_AMP);
                        open_end = 1'b1;
                    end
                    default: text_draft.push_back(mteu_pkg::CH_AMP);
                endcase
            end
        end
        foreach (text_draft[i]) begin
            req_items.push_back('{text_draft[i], i == text_draft.size() - 1, 1'b0, NO_TYPED});
        end
    endfunction

    initial begin : drive_requests
        t_text_req item;
        req_if.valid   <= 1'b0;
        req_if.in_byte <= '0;
        req_if.in_last <= 1'b0;
        i_rst_n        <= 1'b0;
        clear_text_state();
        foreach (DIRECTED[i]) req_items.push_back(DIRECTED[i]);
        while (req_items.size() < DIRECTED_ROWS + RANDOM_ITEMS) draft_random_text();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < req_items.size(); n++) begin
            item = req_items[n];
            @(negedge i_clk);
            // drain everything before the next request
            if (n == PAUSE_AT) begin
                req_if.valid <= 1'b0;
                do @(negedge i_clk); while (plain_text_expected.size() != 0);
            end
            while (!(n >= REQ_CALM_FROM && n < REQ_CALM_TO) &&
                   $urandom_range(99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
            end
            req_if.valid   <= 1'b1;
            req_if.in_byte <= item.in_byte;
            req_if.in_last <= item.is_final;
            do @(posedge i_clk); while (!req_if.ready);
            predict_plain_text(item.in_byte, item.is_final);
            if (item.fixed) begin
                plain_text_expected.push_back(item.typed);
            end else begin
                foreach (decoded_bytes[k]) plain_text_expected.push_back(decoded_bytes[k]);
            end
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (plain_text_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && plain_text_expected.size() == 0) begin
            $display("PASS markup_text_extract_unescape_top");
        end else begin
            $display("FAIL markup_text_extract_unescape_top");
        end
        $finish;
    end

    initial begin : drive_result_ready
        int unsigned cyc;
        cyc = 0;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cyc++;
            // hold off long enough to fill the block and back up the requests
            if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_LEN) begin
                res_if.ready <= 1'b0;
            end else if (cyc >= RES_CALM_FROM && cyc < RES_CALM_TO) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_text_result got;
        t_text_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.out_byte, res_if.byte_valid, res_if.end_of_text,
                    res_if.decode_error};
            if (plain_text_expected.size() == 0) begin
                $display("%0t: unexpected result byte=%02h valid=%0b end=%0b err=%0b",
                         $time, got.out_byte, got.byte_valid, got.end_of_text,
                         got.decode_error);
                fail_count++;
            end else begin
                want = plain_text_expected.pop_front();
                if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                    got.end_of_text !== want.end_of_text ||
                    got.decode_error !== want.decode_error) begin
                    $display("%0t: mismatch expected byte=%02h valid=%0b end=%0b err=%0b",
                             $time, want.out_byte, want.byte_valid, want.end_of_text,
                             want.decode_error);
                    $display("%0t:            actual byte=%02h valid=%0b end=%0b err=%0b",
                             $time, got.out_byte, got.byte_valid, got.end_of_text,
                             got.decode_error);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL markup_text_extract_unescape_top");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mteu_pkg.sv
src/mteu_in_if.sv
src/mteu_out_if.sv
src/markup_text_extract_unescape_top.sv
tb/tb_markup_text_extract_unescape_top.sv
